// ===== design/sorted_timeout_queue_assert.svh =====
// Assertion macros used by the timer queue RTL.
`ifndef SORTED_TIMEOUT_QUEUE_ASSERT_SVH
`define SORTED_TIMEOUT_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define STQ_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer queue check failed");

// Next-cycle implication, disabled during reset.
`define STQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer queue check failed");

`endif

// ===== design/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants of the sorted timeout queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stq_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);

  localparam logic [1:0] M_SCHED = 2'd0;
  localparam logic [1:0] M_DEL   = 2'd1;
  localparam logic [1:0] M_QUERY = 2'd2;
  localparam logic [1:0] M_TICK  = 2'd3;

  localparam logic [2:0] K_SCHED = 3'd0;
  localparam logic [2:0] K_DEL   = 3'd1;
  localparam logic [2:0] K_PEND  = 3'd2;
  localparam logic [2:0] K_EXP   = 3'd3;
  localparam logic [2:0] K_DONE  = 3'd4;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] expiry;
    logic        programmed;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  id;
    logic        answer;
    logic        full;
    logic        pv;
    logic [31:0] delay;
    logic        last;
  } result_t;

endpackage

// ===== design/sorted_timeout_queue.sv =====
// Schedule, delete and query search the table entry by entry, from the head; schedule and
// delete then shift entries to close or open a slot.
// Tick reports each expired head entry, then moves the remaining entries down to close the gap.
// One item is handled at a time; stalls on the result channel hold up the item in progress.
// Reset is synchronous and empties the table at once; no clearing pass.
`timescale 1ns / 1ps

module sorted_timeout_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  timer_id,
  input  logic [31:0] expiry_time,
  input  logic [31:0] now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  result_id,
  output logic        answer,
  output logic        table_full,
  output logic        program_valid,
  output logic [31:0] program_delay,
  output logic        last
);

  `include "sorted_timeout_queue_assert.svh"

  localparam int CW = stq_pkg::CNT_W;
  localparam int IW = stq_pkg::IDX_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOC_RD = 4'd1;
  localparam logic [3:0] S_LOC_EV = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_RM_RD  = 4'd4;
  localparam logic [3:0] S_RM_EV  = 4'd5;
  localparam logic [3:0] S_INS_RD = 4'd6;
  localparam logic [3:0] S_INS_EV = 4'd7;
  localparam logic [3:0] S_PH_RD  = 4'd8;
  localparam logic [3:0] S_PH_EV  = 4'd9;
  localparam logic [3:0] S_PH1_EV = 4'd10;
  localparam logic [3:0] S_TK_RD  = 4'd11;
  localparam logic [3:0] S_TK_EV  = 4'd12;
  localparam logic [3:0] S_CP_RD  = 4'd13;
  localparam logic [3:0] S_CP_EV  = 4'd14;
  localparam logic [3:0] S_EMIT   = 4'd15;

  logic [3:0]  state, state_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] skip, skip_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] count, count_next;
  logic        found, found_next;
  logic [1:0]  mode_r;
  logic [7:0]  id_r;
  logic [31:0] exp_r;
  logic [31:0] now_r;
  stq_pkg::result_t res, res_next;

  logic            we;
  logic [IW-1:0]   waddr, raddr;
  stq_pkg::entry_t wdata, rdata;
  logic            load, free, accept;
  logic [2:0]      ack_kind;
  logic [31:0]     head_delay;
  stq_pkg::entry_t new_entry;
  logic            out_is_ack;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign ack_kind  = (mode_r == stq_pkg::M_SCHED) ? stq_pkg::K_SCHED : stq_pkg::K_DEL;
  assign head_delay = (rdata.expiry > now_r) ? (rdata.expiry - now_r) : 32'd0;
  assign new_entry = '{id: id_r, expiry: exp_r, programmed: 1'b0};
  assign out_is_ack = (kind == stq_pkg::K_SCHED) || (kind == stq_pkg::K_DEL);

  stq_ram #(.WIDTH(stq_pkg::ENTRY_W), .DEPTH(stq_pkg::NUM_TIMERS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  stq_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .res           (res),
    .out_stall     (out_stall),
    .free          (free),
    .out_valid     (out_valid),
    .kind          (kind),
    .result_id     (result_id),
    .answer        (answer),
    .table_full    (table_full),
    .program_valid (program_valid),
    .program_delay (program_delay),
    .last          (last)
  );

  always_comb begin
    state_next = state;
    idx_next   = idx;
    skip_next  = skip;
    pos_next   = pos;
    count_next = count;
    found_next = found;
    res_next   = res;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    raddr      = '0;
    load       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          idx_next   = '0;
          found_next = 1'b0;
          state_next = (mode == stq_pkg::M_TICK) ? S_TK_RD : S_LOC_RD;
        end
      end
      S_LOC_RD: begin
        raddr = idx[IW-1:0];
        state_next = (idx == count) ? S_DECIDE : S_LOC_EV;
      end
      S_LOC_EV: begin
        if (rdata.id == id_r) begin
          found_next = 1'b1;
          pos_next   = idx;
          state_next = S_DECIDE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_LOC_RD;
        end
      end
      S_DECIDE: begin
        if (mode_r == stq_pkg::M_QUERY) begin
          res_next = '{kind: stq_pkg::K_PEND, id: id_r, answer: found, full: 1'b0,
                       pv: 1'b0, delay: 32'd0, last: 1'b1};
          state_next = S_EMIT;
        end else if (!found && mode_r == stq_pkg::M_SCHED &&
                     count == CW'(stq_pkg::NUM_TIMERS)) begin
          res_next = '{kind: stq_pkg::K_SCHED, id: id_r, answer: 1'b0, full: 1'b1,
                       pv: 1'b0, delay: 32'd0, last: 1'b1};
          state_next = S_EMIT;
        end else if (found) begin
          idx_next   = pos;
          state_next = S_RM_RD;
        end else if (mode_r == stq_pkg::M_SCHED) begin
          idx_next   = count;
          state_next = S_INS_RD;
        end else begin
          state_next = S_PH_RD;
        end
      end
      S_RM_RD: begin
        raddr = IW'(idx + 1'b1);
        if (CW'(idx + 1'b1) >= count) begin
          count_next = count - 1'b1;
          idx_next   = count - 1'b1;
          state_next = (mode_r == stq_pkg::M_SCHED) ? S_INS_RD : S_PH_RD;
        end else begin
          state_next = S_RM_EV;
        end
      end
      S_RM_EV: begin
        we         = 1'b1;
        waddr      = idx[IW-1:0];
        wdata      = rdata;
        idx_next   = idx + 1'b1;
        state_next = S_RM_RD;
      end
      // Walk down from the top, moving later entries up one place until the
      // slot for the new timer is found.
      S_INS_RD: begin
        raddr = IW'(idx - 1'b1);
        if (idx == '0) begin
          we         = 1'b1;
          waddr      = '0;
          wdata      = new_entry;
          count_next = count + 1'b1;
          state_next = S_PH_RD;
        end else begin
          state_next = S_INS_EV;
        end
      end
      S_INS_EV: begin
        we    = 1'b1;
        waddr = idx[IW-1:0];
        if (rdata.expiry < exp_r) begin
          wdata      = new_entry;
          count_next = count + 1'b1;
          state_next = S_PH_RD;
        end else begin
          wdata      = rdata;
          idx_next   = idx - 1'b1;
          state_next = S_INS_RD;
        end
      end
      S_PH_RD: begin
        raddr = '0;
        if (count == '0) begin
          res_next = '{kind: ack_kind, id: id_r, answer: found, full: 1'b0,
                       pv: 1'b0, delay: 32'd0, last: 1'b1};
          state_next = S_EMIT;
        end else begin
          state_next = S_PH_EV;
        end
      end
      S_PH_EV: begin
        raddr = IW'(1);
        res_next = '{kind: ack_kind, id: id_r, answer: found, full: 1'b0,
                     pv: !rdata.programmed, delay: rdata.programmed ? 32'd0 : head_delay,
                     last: 1'b1};
        if (rdata.programmed) begin
          state_next = S_EMIT;
        end else begin
          we         = 1'b1;
          waddr      = '0;
          wdata      = '{id: rdata.id, expiry: rdata.expiry, programmed: 1'b1};
          state_next = (count > CW'(1)) ? S_PH1_EV : S_EMIT;
        end
      end
      S_PH1_EV: begin
        we         = 1'b1;
        waddr      = IW'(1);
        wdata      = '{id: rdata.id, expiry: rdata.expiry, programmed: 1'b0};
        state_next = S_EMIT;
      end
      S_TK_RD: begin
        raddr = idx[IW-1:0];
        if (idx == count) begin
          skip_next  = idx;
          idx_next   = '0;
          state_next = S_CP_RD;
        end else begin
          state_next = S_TK_EV;
        end
      end
      S_TK_EV: begin
        if (rdata.expiry <= now_r) begin
          res_next = '{kind: stq_pkg::K_EXP, id: rdata.id, answer: 1'b0, full: 1'b0,
                       pv: 1'b0, delay: 32'd0, last: 1'b0};
          idx_next   = idx + 1'b1;
          state_next = S_EMIT;
        end else begin
          skip_next  = idx;
          idx_next   = '0;
          state_next = S_CP_RD;
        end
      end
      // Close the gap left by the expired head entries.
      S_CP_RD: begin
        raddr = IW'(idx + skip);
        if (CW'(idx + skip) >= count) begin
          count_next = count - skip;
          res_next = '{kind: stq_pkg::K_DONE, id: 8'd0, answer: 1'b0, full: 1'b0,
                       pv: 1'b0, delay: 32'd0, last: 1'b1};
          state_next = S_EMIT;
        end else begin
          state_next = S_CP_EV;
        end
      end
      S_CP_EV: begin
        we         = 1'b1;
        waddr      = idx[IW-1:0];
        wdata      = rdata;
        idx_next   = idx + 1'b1;
        state_next = S_CP_RD;
      end
      S_EMIT: begin
        if (free) begin
          load       = 1'b1;
          state_next = res.last ? S_IDLE : S_TK_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx   <= idx_next;
    skip  <= skip_next;
    pos   <= pos_next;
    found <= found_next;
    res   <= res_next;
    if (accept) begin
      mode_r <= mode;
      id_r   <= timer_id;
      exp_r  <= expiry_time;
      now_r  <= now;
    end
  end

  `STQ_ASSERT_IMPLIES(a_count_bound, 1'b1, count <= CW'(stq_pkg::NUM_TIMERS))
  `STQ_ASSERT_NEXT(a_busy_after_accept, accept, in_stall)
  `STQ_ASSERT_IMPLIES(a_program_on_ack, out_valid && program_valid, out_is_ack)

endmodule

// ===== design/stq_ram.sv =====
// ----------------------------------------------------------------------------
// stq_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/stq_out.sv =====
// ----------------------------------------------------------------------------
// stq_out
// Output register of the result channel; frees itself on a transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stq_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  stq_pkg::result_t res,
  input  logic             out_stall,
  output logic             free,
  output logic             out_valid,
  output logic [2:0]       kind,
  output logic [7:0]       result_id,
  output logic             answer,
  output logic             table_full,
  output logic             program_valid,
  output logic [31:0]      program_delay,
  output logic             last
);

  stq_pkg::result_t held;

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign kind          = held.kind;
  assign result_id     = held.id;
  assign answer        = held.answer;
  assign table_full    = held.full;
  assign program_valid = held.pv;
  assign program_delay = held.delay;
  assign last          = held.last;

endmodule

// ===== test/stq_checker.sv =====
// ----------------------------------------------------------------------------
// Timer queue scoreboard
// Watches both channels of the sorted timeout queue, keeps a shadow copy of
// the timer table, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stq_checker
  import stq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  timer_id,
  input  logic [31:0] expiry_time,
  input  logic [31:0] now,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  kind,
  input  logic [7:0]  result_id,
  input  logic        answer,
  input  logic        table_full,
  input  logic        program_valid,
  input  logic [31:0] program_delay,
  input  logic        last,
  output int          errors,
  output int          pending
);

  logic [7:0]  shadow_id [NUM_TIMERS];
  logic [31:0] shadow_exp [NUM_TIMERS];
  logic        shadow_prog [NUM_TIMERS];
  int          shadow_count;
  result_t     expected_results [$];

  function automatic result_t make_result(logic [2:0] k, logic [7:0] id, logic ans,
                                          logic full, logic pv, logic [31:0] dly,
                                          logic lst);
    result_t r;
    r.kind = k; r.id = id; r.answer = ans; r.full = full;
    r.pv = pv; r.delay = dly; r.last = lst;
    return r;
  endfunction

  function automatic int find_timer(logic [7:0] id);
    for (int i = 0; i < shadow_count; i++)
      if (shadow_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void remove_timer(int pos);
    for (int i = pos; i + 1 < shadow_count; i++) begin
      shadow_id[i] = shadow_id[i+1];
      shadow_exp[i] = shadow_exp[i+1];
      shadow_prog[i] = shadow_prog[i+1];
    end
    shadow_count--;
  endfunction

  function automatic void insert_timer(logic [7:0] id, logic [31:0] exp);
    int pos;
    pos = 0;
    while (pos < shadow_count && shadow_exp[pos] < exp) pos++;
    for (int i = shadow_count; i > pos; i--) begin
      shadow_id[i] = shadow_id[i-1];
      shadow_exp[i] = shadow_exp[i-1];
      shadow_prog[i] = shadow_prog[i-1];
    end
    shadow_id[pos] = id;
    shadow_exp[pos] = exp;
    shadow_prog[pos] = 1'b0;
    shadow_count++;
  endfunction

  // Arms the head if it is not yet marked; returns the delay in dly.
  function automatic logic arm_head(logic [31:0] t, output logic [31:0] dly);
    dly = '0;
    if (shadow_count == 0 || shadow_prog[0]) return 1'b0;
    if (shadow_exp[0] > t) dly = shadow_exp[0] - t;
    shadow_prog[0] = 1'b1;
    if (shadow_count > 1) shadow_prog[1] = 1'b0;
    return 1'b1;
  endfunction

  task automatic predict_timer_op(logic [1:0] m, logic [7:0] id, logic [31:0] exp,
                                  logic [31:0] t);
    int          pos;
    logic        pv;
    logic [31:0] dly;
    pos = find_timer(id);
    case (m)
      M_SCHED: begin
        if (pos < 0 && shadow_count >= NUM_TIMERS) begin
          expected_results.push_back(make_result(K_SCHED, id, 1'b0, 1'b1, 1'b0, 32'd0,
                                                 1'b1));
        end else begin
          if (pos >= 0) remove_timer(pos);
          insert_timer(id, exp);
          pv = arm_head(t, dly);
          expected_results.push_back(make_result(K_SCHED, id, pos >= 0, 1'b0, pv, dly,
                                                 1'b1));
        end
      end
      M_DEL: begin
        if (pos >= 0) remove_timer(pos);
        pv = arm_head(t, dly);
        expected_results.push_back(make_result(K_DEL, id, pos >= 0, 1'b0, pv, dly, 1'b1));
      end
      M_QUERY: begin
        expected_results.push_back(make_result(K_PEND, id, pos >= 0, 1'b0, 1'b0, 32'd0,
                                               1'b1));
      end
      default: begin
        while (shadow_count > 0 && shadow_exp[0] <= t) begin
          expected_results.push_back(make_result(K_EXP, shadow_id[0], 1'b0, 1'b0, 1'b0,
                                                 32'd0, 1'b0));
          remove_timer(0);
        end
        expected_results.push_back(make_result(K_DONE, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0,
                                               1'b1));
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      shadow_count = 0;
      for (int i = 0; i < NUM_TIMERS; i++) shadow_prog[i] = 1'b0;
      expected_results.delete();
      errors = 0;
      pending = 0;
    end else begin
      // Check the output first: a result cannot come from an item accepted this edge.
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer: kind %0d id %0d", kind, result_id);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (kind !== exp_r.kind) begin
            $error("kind expected %0d actual %0d", exp_r.kind, kind); errors++;
          end
          if (result_id !== exp_r.id) begin
            $error("result_id expected %0d actual %0d", exp_r.id, result_id); errors++;
          end
          if (answer !== exp_r.answer) begin
            $error("answer expected %0d actual %0d", exp_r.answer, answer); errors++;
          end
          if (table_full !== exp_r.full) begin
            $error("table_full expected %0d actual %0d", exp_r.full, table_full); errors++;
          end
          if (program_valid !== exp_r.pv) begin
            $error("program_valid expected %0d actual %0d", exp_r.pv, program_valid);
            errors++;
          end
          if (program_delay !== exp_r.delay) begin
            $error("program_delay expected %0d actual %0d", exp_r.delay, program_delay);
            errors++;
          end
          if (last !== exp_r.last) begin
            $error("last expected %0d actual %0d", exp_r.last, last); errors++;
          end
        end
      end
      if (in_valid && !in_stall) predict_timer_op(mode, timer_id, expiry_time, now);
      pending = expected_results.size();
    end
  end

endmodule

// ===== test/tb_sorted_timeout_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted timeout queue testbench
// Drives directed and random timer operations with random idling on both
// channels; a separate scoreboard predicts and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_timeout_queue;
  import stq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = M_QUERY;
  logic [7:0]  timer_id = '0;
  logic [31:0] expiry_time = '0;
  logic [31:0] now = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  result_id;
  logic        answer;
  logic        table_full;
  logic        program_valid;
  logic [31:0] program_delay;
  logic        last;
  int          errors;
  int          pending;
  int          cycle_count = 0;
  logic        calm = 1'b0;
  logic        hold_off = 1'b0;
  logic [31:0] clock_now = 32'd1000;

  always #4 clk = ~clk;

  sorted_timeout_queue dut (.*);
  stq_checker scoreboard (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver idling: random stall bursts, or one long hold-off on request.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (n - 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Valid stays high after the transfer; the next call either drives a new
  // item or idles, so valid is assigned once per edge.
  task automatic send_op(logic [1:0] m, logic [7:0] id, logic [31:0] exp,
                         logic [31:0] t);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    timer_id <= id;
    expiry_time <= exp;
    now <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_op();
    int          r;
    logic [7:0]  id;
    logic [31:0] exp;
    r = $urandom_range(0, 99);
    // A small id pool makes reschedules, hits and table-full cases common.
    id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 23));
    exp = clock_now + $urandom_range(0, 400);
    if ($urandom_range(0, 19) == 0) exp = $urandom;
    if (r < 45) send_op(M_SCHED, id, exp, clock_now);
    else if (r < 60) send_op(M_DEL, id, 32'($urandom), clock_now);
    else if (r < 75) send_op(M_QUERY, id, 32'($urandom), clock_now);
    else begin
      clock_now = clock_now + $urandom_range(0, 150);
      send_op(M_TICK, id, 32'($urandom), clock_now);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-table cases, extremes, equal expiries, overfill, tick.
    send_op(M_QUERY, 8'd0, 32'd0, 32'd0);
    send_op(M_DEL, 8'd255, 32'hFFFF_FFFF, 32'd0);
    send_op(M_TICK, 8'd0, 32'd0, 32'd0);
    send_op(M_SCHED, 8'd255, 32'hFFFF_FFFF, 32'd0);
    send_op(M_SCHED, 8'd0, 32'd0, 32'hFFFF_FFFF);
    send_op(M_SCHED, 8'd7, 32'd500, 32'd100);
    send_op(M_SCHED, 8'd8, 32'd500, 32'd100);
    send_op(M_SCHED, 8'd7, 32'd600, 32'd100);
    send_op(M_QUERY, 8'd7, 32'd0, 32'd100);
    send_op(M_DEL, 8'd0, 32'd0, 32'd100);
    for (int i = 0; i < 15; i++)
      send_op(M_SCHED, 8'(20 + i), 32'(700 + 3 * i), 32'd100);
    send_op(M_TICK, 8'd0, 32'd0, 32'hFFFF_FFFF);

    // Fill the table while the receiver holds off, so the input stalls.
    hold_off = 1'b1;
    for (int i = 0; i < 18; i++)
      send_op(M_SCHED, 8'(40 + i), 32'(1000 + $urandom_range(0, 50)), 32'd900);
    drain_results();
    send_op(M_TICK, 8'd0, 32'd0, 32'd2000);

    for (int i = 0; i < 235; i++) begin
      if (i == 100) drain_results();
      if (i == 195) calm = 1'b1;
      random_op();
    end
    drain_results();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/stq_pkg.sv
design/stq_ram.sv
design/stq_out.sv
design/sorted_timeout_queue.sv
test/stq_checker.sv
test/tb_sorted_timeout_queue.sv
